// ----- sv/dbcc_pkg.sv -----
package dbcc_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY      = 1'b1;

  // reset values and defaults
  localparam logic [15:0] INITIAL_WINDOW_RST = 16'd32;
  localparam logic [9:0]  MAX_DELAY_RST      = 10'd80;
  localparam int          HISTORY_DEPTH_DEF  = 4;

  // 1.5 in Q16.16
  localparam logic [16:0] GROW_Q16 = 17'd98304;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (|v[31:16]) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ----- sv/delay_based_cwnd_controller_core.sv -----
// A send request goes from idle straight to S_FIN, which loads the output register.
// An ack runs the ring read, the least-squares fit and the window update when a prediction is made
// (MB = 17+log2(D) multiplier bits and PW = 51+3*log2(D) quotient bits for history depth D).
// Otherwise it skips the fit and goes straight to the window update.
// One request at a time; the bit-serial multiplier and divider set the rate.
// A new request is taken while the previous result waits in the output register.
// Reset (rst_n low, synchronous) loads window 32, max delay 80 and clears all control.
module delay_based_cwnd_controller_core #(
  parameter int HISTORY_DEPTH = dbcc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [31:0]                    in_seq_number,
  input  logic [31:0]                    in_send_time,
  input  logic [31:0]                    in_ack_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    out_window,
  output logic [9:0]                     out_timeout,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dbcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import dbcc_pkg::*;

  // widths follow from the history depth
  localparam int LG   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int IW   = LG;
  localparam int FIW  = $clog2(HISTORY_DEPTH + 1);
  localparam int SW   = 16 + LG;        // sum of x or of y
  localparam int QW   = 32 + LG;        // sum of x*x or x*y
  localparam int NW   = 34 + 2 * LG;    // signed den / num
  localparam int MA   = 32 + 2 * LG;    // multiplicand
  localparam int MB   = 17 + LG;        // multiplier, one bit per cycle
  localparam int PRW  = MA + MB;        // product
  localparam int PW   = PRW + 2;        // signed p, dividend, quotient
  localparam int FW   = 19 + LG;        // signed n*xp - sx
  localparam int DVW  = 32 + 3 * LG;    // divisor
  localparam int MCW  = $clog2(MB + 1);
  localparam int DCW  = $clog2(PW + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_ACK, S_ORD, S_OLD, S_LOAD, S_MXX, S_MXY, S_MSS, S_MSY, S_DEN,
    S_MT1, S_MT2, S_PDIV, S_PQ, S_UPD, S_CMUL, S_CDIV, S_GMUL, S_GDIV, S_FIN
  } state_t;

  state_t state_r;

  // configuration and window state
  logic [9:0]  max_delay_r;
  logic [15:0] win_r;
  logic [31:0] acc_r;
  logic [15:0] min_rtt_r;
  logic [15:0] last_rtt_r;
  logic [31:0] last_seq_r;
  logic [31:0] flight_r;
  logic [31:0] last_ack_r;
  logic [IW-1:0]  pos_r;
  logic [FIW-1:0] fill_r;

  // history ring
  logic [31:0] time_mem [HISTORY_DEPTH];
  logic [15:0] rtt_mem  [HISTORY_DEPTH];
  logic [31:0] t_rd_r;
  logic [15:0] r_rd_r;
  logic [IW-1:0] rd_addr;
  logic          mem_we;

  // captured request and working registers
  logic [31:0] seq_r, snd_r, ack_r;
  logic        is_ack_r;
  logic        pred_r;
  logic [15:0] used_r;
  logic [15:0] gap_r;
  logic [31:0] oldest_r;
  logic [IW-1:0] idx_r;
  logic [15:0] x_r, y_r;
  logic [SW-1:0] sx_r, sy_r;
  logic [QW-1:0] sxx_r, sxy_r;
  logic [MA-1:0] sxsx_r;
  logic signed [NW-1:0] den_r, num_r;
  logic signed [FW-1:0] f_r;
  logic [PRW-1:0] t1_r;
  logic signed [PW-1:0] p_r;
  logic [16:0] d_r;

  logic        out_valid_r;
  logic [15:0] out_window_r;
  logic [9:0]  out_timeout_r;

  // serial multiplier
  logic [MA-1:0]  mul_a_r;
  logic [PRW-1:0] mul_p_r;
  logic [MCW-1:0] mul_cnt_r;
  logic           mul_busy_r;
  logic           mul_start;
  logic [MA-1:0]  mul_a;
  logic [MB-1:0]  mul_b;
  logic [MA:0]    mul_sum;

  // serial restoring divider
  logic [DVW-1:0] div_d_r;
  logic [DVW-1:0] div_rem_r;
  logic [PW-1:0]  div_q_r;
  logic [DCW-1:0] div_cnt_r;
  logic           div_busy_r;
  logic           div_start;
  logic [PW-1:0]  div_n;
  logic [DVW-1:0] div_d;
  logic [DVW:0]   div_sh, div_diff;

  // combinational helpers
  logic [15:0] rtt_meas;
  logic [16:0] two_min;
  logic [9:0]  t_now;
  logic [15:0] x_cur;
  logic        full, dup;
  logic [IW-1:0] pos_nxt;
  logic        over;
  logic        falling;
  logic [15:0] w_eff;
  logic [16:0] xp;
  logic [MA-1:0] num_mag;
  logic [MB-1:0] f_mag;
  logic          prod_neg;
  logic [DVW-1:0] q_val;
  logic          p_pos;
  logic [16:0]   gv;
  logic [18:0]   gv3;
  logic [15:0]   half_win;
  logic [PW-1:0] acc_sum;
  logic [31:0]   acc_new;
  logic          den_pos;

  assign rtt_meas = sat16(ack_r - snd_r);
  assign two_min  = {min_rtt_r, 1'b0};
  assign t_now    = (two_min < {7'd0, max_delay_r}) ? two_min[9:0] : max_delay_r;
  assign x_cur    = sat16(t_rd_r - oldest_r);
  assign full     = (fill_r >= FIW'(HISTORY_DEPTH));
  assign dup      = full && (ack_r == last_ack_r);
  assign pos_nxt  = (pos_r == LAST_IDX) ? '0 : pos_r + IW'(1);
  assign over     = (used_r > {6'd0, t_now});
  assign falling  = (used_r < last_rtt_r);
  assign w_eff    = (win_r == 16'd0) ? 16'd1 : win_r;
  assign xp       = {1'b0, sat16(ack_r - oldest_r)} + {1'b0, gap_r};
  assign num_mag  = num_r[NW-1] ? MA'(-num_r) : MA'(num_r);
  assign f_mag    = f_r[FW-1] ? MB'(-f_r) : MB'(f_r);
  assign prod_neg = num_r[NW-1] ^ f_r[FW-1];
  assign q_val    = DVW'(den_r) * DVW'(HISTORY_DEPTH);
  assign p_pos    = !p_r[PW-1] && (p_r != '0);
  assign den_pos  = !den_r[NW-1] && (den_r != '0);
  assign gv       = {last_rtt_r, 1'b0} - {1'b0, used_r};
  assign gv3      = {2'b00, gv} + {1'b0, gv, 1'b0};
  assign half_win = 16'((17'(win_r) + 17'd1) >> 1);
  assign acc_sum  = PW'(acc_r) + div_q_r;
  assign acc_new  = (|acc_sum[PW-1:32]) ? 32'hFFFF_FFFF :
                    ((acc_sum[31:0] < 32'h0001_0000) ? 32'h0001_0000 : acc_sum[31:0]);

  assign in_ready    = (state_r == S_IDLE);
  assign cfg_ready   = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_window  = out_window_r;
  assign out_timeout = out_timeout_r;

  // ring read address: oldest slot first, then each slot in turn
  always_comb begin
    case (state_r)
      S_ORD:   rd_addr = pos_r;
      S_OLD:   rd_addr = '0;
      S_MXY:   rd_addr = idx_r + IW'(1);
      default: rd_addr = idx_r;
    endcase
  end

  assign mem_we = (state_r == S_ACK);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[pos_r] <= ack_r;
      rtt_mem[pos_r]  <= rtt_meas;
    end
    t_rd_r <= time_mem[rd_addr];
    r_rd_r <= rtt_mem[rd_addr];
  end

  // multiplier operands
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      S_LOAD: begin
        mul_start = 1'b1;
        mul_a     = MA'(x_cur);
        mul_b     = MB'(x_cur);
      end
      S_MXX: begin
        mul_start = !mul_busy_r;
        mul_a     = MA'(x_r);
        mul_b     = MB'(y_r);
      end
      S_MXY: begin
        mul_start = !mul_busy_r && (idx_r == LAST_IDX);
        mul_a     = MA'(sx_r);
        mul_b     = MB'(sx_r);
      end
      S_MSS: begin
        mul_start = !mul_busy_r;
        mul_a     = MA'(sx_r);
        mul_b     = MB'(sy_r);
      end
      S_DEN: begin
        mul_start = den_pos;
        mul_a     = MA'(den_r);
        mul_b     = MB'(sy_r);
      end
      S_MT1: begin
        mul_start = !mul_busy_r;
        mul_a     = num_mag;
        mul_b     = f_mag;
      end
      S_UPD: begin
        if (over) begin
          mul_start = (flight_r == 32'd0) && !pred_r;
          mul_a     = MA'(win_r);
          mul_b     = MB'(t_now);
        end else begin
          mul_start = falling;
          mul_a     = MA'(last_rtt_r);
          mul_b     = MB'(w_eff);
        end
      end
      default: ;
    endcase
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    unique case (state_r)
      S_PDIV: begin
        div_start = p_pos;
        div_n     = PW'(p_r) + PW'(q_val) - PW'(1);
        div_d     = q_val;
      end
      S_CMUL: begin
        div_start = !mul_busy_r;
        div_n     = PW'(mul_p_r) + PW'(d_r) - PW'(1);
        div_d     = DVW'(d_r);
      end
      S_UPD: begin
        div_start = !over && !falling;
        div_n     = PW'(GROW_Q16);
        div_d     = DVW'(w_eff);
      end
      S_GMUL: begin
        div_start = !mul_busy_r;
        div_n     = PW'(gv3) << 16;
        div_d     = DVW'(mul_p_r[31:0]);
      end
      default: ;
    endcase
  end

  // shift-add multiplier, one multiplier bit per cycle
  assign mul_sum = {1'b0, mul_p_r[PRW-1:MB]} + (mul_p_r[0] ? {1'b0, mul_a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
    end else if (mul_start) begin
      mul_a_r    <= mul_a;
      mul_p_r    <= {{MA{1'b0}}, mul_b};
      mul_cnt_r  <= MCW'(MB);
      mul_busy_r <= 1'b1;
    end else if (mul_busy_r) begin
      mul_p_r   <= {mul_sum, mul_p_r[MB-1:1]};
      mul_cnt_r <= mul_cnt_r - MCW'(1);
      if (mul_cnt_r == MCW'(1)) begin
        mul_busy_r <= 1'b0;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign div_sh   = {div_rem_r, div_q_r[PW-1]};
  assign div_diff = div_sh - {1'b0, div_d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (div_start) begin
      div_d_r    <= div_d;
      div_rem_r  <= '0;
      div_q_r    <= div_n;
      div_cnt_r  <= DCW'(PW);
      div_busy_r <= 1'b1;
    end else if (div_busy_r) begin
      div_rem_r <= div_diff[DVW] ? div_sh[DVW-1:0] : div_diff[DVW-1:0];
      div_q_r   <= {div_q_r[PW-2:0], !div_diff[DVW]};
      div_cnt_r <= div_cnt_r - DCW'(1);
      if (div_cnt_r == DCW'(1)) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  // sequencer and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      max_delay_r <= MAX_DELAY_RST;
      win_r       <= INITIAL_WINDOW_RST;
      acc_r       <= {INITIAL_WINDOW_RST, 16'd0};
      min_rtt_r   <= {6'd0, MAX_DELAY_RST};
      last_rtt_r  <= '0;
      last_seq_r  <= '0;
      flight_r    <= '0;
      last_ack_r  <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
    end else begin
      // S_FIN reloads the output register itself
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            seq_r    <= in_seq_number;
            snd_r    <= in_send_time;
            ack_r    <= in_ack_time;
            is_ack_r <= in_action;
            if (!in_action) begin
              last_seq_r <= in_seq_number;
              state_r    <= S_FIN;
            end else begin
              state_r <= S_ACK;
            end
          end
        end

        // rtt, minimum, ring bookkeeping
        S_ACK: begin
          if (rtt_meas < min_rtt_r) begin
            min_rtt_r <= rtt_meas;
          end
          last_ack_r <= ack_r;
          gap_r      <= sat16(ack_r - last_ack_r);
          used_r     <= rtt_meas;
          pred_r     <= full && !dup;
          if (!dup) begin
            pos_r <= pos_nxt;
            if (!full) begin
              fill_r <= fill_r + FIW'(1);
            end
          end
          state_r <= (full && !dup) ? S_ORD : S_UPD;
        end

        S_ORD: state_r <= S_OLD;

        S_OLD: begin
          oldest_r <= t_rd_r;
          idx_r    <= '0;
          sx_r     <= '0;
          sy_r     <= '0;
          sxx_r    <= '0;
          sxy_r    <= '0;
          state_r  <= S_LOAD;
        end

        S_LOAD: begin
          x_r     <= x_cur;
          y_r     <= r_rd_r;
          sx_r    <= sx_r + SW'(x_cur);
          sy_r    <= sy_r + SW'(r_rd_r);
          state_r <= S_MXX;
        end

        S_MXX: begin
          if (!mul_busy_r) begin
            sxx_r   <= sxx_r + QW'(mul_p_r);
            state_r <= S_MXY;
          end
        end

        S_MXY: begin
          if (!mul_busy_r) begin
            sxy_r <= sxy_r + QW'(mul_p_r);
            if (idx_r == LAST_IDX) begin
              state_r <= S_MSS;
            end else begin
              idx_r   <= idx_r + IW'(1);
              state_r <= S_LOAD;
            end
          end
        end

        S_MSS: begin
          if (!mul_busy_r) begin
            sxsx_r  <= MA'(mul_p_r);
            state_r <= S_MSY;
          end
        end

        S_MSY: begin
          if (!mul_busy_r) begin
            den_r <= $signed(NW'(sxx_r) * NW'(HISTORY_DEPTH)) - $signed(NW'(sxsx_r));
            num_r <= $signed(NW'(sxy_r) * NW'(HISTORY_DEPTH)) - $signed(NW'(mul_p_r));
            state_r <= S_DEN;
          end
        end

        // flat history gives min rtt
        S_DEN: begin
          f_r <= $signed(FW'(xp) * FW'(HISTORY_DEPTH)) - $signed(FW'(sx_r));
          if (den_pos) begin
            state_r <= S_MT1;
          end else begin
            used_r  <= min_rtt_r;
            state_r <= S_UPD;
          end
        end

        S_MT1: begin
          if (!mul_busy_r) begin
            t1_r    <= mul_p_r;
            state_r <= S_MT2;
          end
        end

        S_MT2: begin
          if (!mul_busy_r) begin
            p_r <= prod_neg ? $signed(PW'(t1_r)) - $signed(PW'(mul_p_r))
                            : $signed(PW'(t1_r)) + $signed(PW'(mul_p_r));
            state_r <= S_PDIV;
          end
        end

        // non-positive fit falls below min rtt
        S_PDIV: begin
          if (p_pos) begin
            state_r <= S_PQ;
          end else begin
            used_r  <= min_rtt_r;
            state_r <= S_UPD;
          end
        end

        S_PQ: begin
          if (!div_busy_r) begin
            if (div_q_r < PW'(min_rtt_r)) begin
              used_r <= min_rtt_r;
            end else begin
              used_r <= (|div_q_r[PW-1:16]) ? 16'hFFFF : div_q_r[15:0];
            end
            state_r <= S_UPD;
          end
        end

        S_UPD: begin
          if (over) begin
            if (flight_r == 32'd0) begin
              if (pred_r) begin
                win_r    <= half_win;
                acc_r    <= {half_win, 16'd0};
                flight_r <= last_seq_r - seq_r;
                state_r  <= S_FIN;
              end else begin
                d_r     <= {used_r, 1'b0} - {7'd0, t_now};
                state_r <= S_CMUL;
              end
            end else begin
              flight_r <= flight_r - 32'd1;
              state_r  <= S_FIN;
            end
          end else begin
            state_r <= falling ? S_GMUL : S_GDIV;
          end
        end

        S_CMUL: begin
          if (!mul_busy_r) begin
            state_r <= S_CDIV;
          end
        end

        // excess-factor cut
        S_CDIV: begin
          if (!div_busy_r) begin
            if (div_q_r[15:0] == 16'd0) begin
              win_r <= 16'd1;
              acc_r <= 32'h0001_0000;
            end else begin
              win_r <= div_q_r[15:0];
              acc_r <= {div_q_r[15:0], 16'd0};
            end
            flight_r <= last_seq_r - seq_r;
            state_r  <= S_FIN;
          end
        end

        S_GMUL: begin
          if (!mul_busy_r) begin
            state_r <= S_GDIV;
          end
        end

        S_GDIV: begin
          if (!div_busy_r) begin
            acc_r   <= acc_new;
            win_r   <= acc_new[31:16];
            state_r <= S_FIN;
          end
        end

        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_window_r  <= win_r;
            out_timeout_r <= t_now;
            if (is_ack_r) begin
              last_rtt_r <= used_r;
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase

      // register writes, only while idle
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_INITIAL_WINDOW: begin
            if (cfg_data == 16'd0) begin
              win_r <= 16'd1;
              acc_r <= 32'h0001_0000;
            end else begin
              win_r <= cfg_data;
              acc_r <= {cfg_data, 16'd0};
            end
          end
          CFG_MAX_DELAY: begin
            max_delay_r <= cfg_data[9:0];
            min_rtt_r   <= {6'd0, cfg_data[9:0]};
          end
          default: ;
        endcase
      end
    end
  end

endmodule
